// ===== src/spcp_pkg.sv =====
// Package for the segment pair closest points block.
// Holds the select code that the mid stage passes to the back end. No dependencies.
`default_nettype none
package spcp_pkg;

  typedef enum logic [1:0] {
    SEL_NONE,
    SEL_F1,
    SEL_F2
  } sel_t;

endpackage
`default_nettype wire

// ===== src/spcp_delay.sv =====
// Delay line with a shared advance enable, used to align side data with the dividers.
// No dependencies.
`default_nettype none
module spcp_delay #(
  parameter int W     = 8,
  parameter int DEPTH = 2
) (
  input  wire logic         clk,
  input  wire logic         en,
  input  wire logic [W-1:0] d,
  output logic      [W-1:0] q
);

  logic [W-1:0] taps [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      taps[0] <= d;
      for (int i = 1; i < DEPTH; i++) begin
        taps[i] <= taps[i-1];
      end
    end
  end

  assign q = taps[DEPTH-1];

endmodule
`default_nettype wire

// ===== src/spcp_div.sv =====
// Pipelined restoring divider giving num/den clamped to [0,1] with QB fraction bits.
// No dependencies.
`default_nettype none
module spcp_div #(
  parameter int W  = 51,
  parameter int QB = 16
) (
  input  wire logic                clk,
  input  wire logic                en,
  input  wire logic signed [W-1:0] num,
  input  wire logic signed [W-1:0] den,
  output logic             [QB:0]  q
);

  logic signed [W-1:0] n0;
  logic signed [W-1:0] d0;
  logic        [W-2:0] rem [QB+1];
  logic        [W-2:0] dv  [QB+1];
  logic        [QB-1:0] qv [QB+1];
  logic                zfv [QB+1];
  logic                ofv [QB+1];

  always_ff @(posedge clk) begin
    if (en) begin
      if (den[W-1]) begin
        n0 <= -num;
        d0 <= -den;
      end else begin
        n0 <= num;
        d0 <= den;
      end
      zfv[0] <= (d0 == '0) || n0[W-1] || (n0 == '0);
      ofv[0] <= (n0 >= d0);
      rem[0] <= n0[W-2:0];
      dv[0]  <= d0[W-2:0];
      qv[0]  <= '0;
    end
  end

  for (genvar k = 0; k < QB; k++) begin : g_iter
    logic [W-1:0] rem2;
    logic [W-1:0] diff;
    logic         ge;
    always_comb begin
      rem2 = {rem[k], 1'b0};
      diff = rem2 - {1'b0, dv[k]};
      ge   = (rem2 >= {1'b0, dv[k]});
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rem[k+1] <= ge ? diff[W-2:0] : rem2[W-2:0];
        dv[k+1]  <= dv[k];
        qv[k+1]  <= {qv[k][QB-2:0], ge};
        zfv[k+1] <= zfv[k];
        ofv[k+1] <= ofv[k];
      end
    end
  end

  assign q = zfv[QB] ? '0 : (ofv[QB] ? {1'b1, {QB{1'b0}}} : {1'b0, qv[QB]});

endmodule
`default_nettype wire

// ===== src/spcp_front.sv =====
// Front end: direction vectors, products and the dot and cross sums, three stages.
// No dependencies.
`default_nettype none
module spcp_front #(
  parameter int CB = 24
) (
  input  wire logic                  clk,
  input  wire logic                  en,
  input  wire logic signed [CB-1:0]  a_sx,
  input  wire logic signed [CB-1:0]  a_sy,
  input  wire logic signed [CB-1:0]  a_ex,
  input  wire logic signed [CB-1:0]  a_ey,
  input  wire logic signed [CB-1:0]  b_sx,
  input  wire logic signed [CB-1:0]  b_sy,
  input  wire logic signed [CB-1:0]  b_ex,
  input  wire logic signed [CB-1:0]  b_ey,
  output logic signed [CB-1:0]       ax,
  output logic signed [CB-1:0]       ay,
  output logic signed [CB-1:0]       bx,
  output logic signed [CB-1:0]       by,
  output logic signed [CB:0]         d1x,
  output logic signed [CB:0]         d1y,
  output logic signed [CB:0]         d2x,
  output logic signed [CB:0]         d2y,
  output logic                       z1,
  output logic                       z2,
  output logic signed [2*CB+2:0]     dd1,
  output logic signed [2*CB+2:0]     dd2,
  output logic signed [2*CB+2:0]     rd1,
  output logic signed [2*CB+2:0]     rd2,
  output logic signed [2*CB+2:0]     d12,
  output logic signed [2*CB+2:0]     cr,
  output logic signed [2*CB+2:0]     cn
);

  localparam int DW = CB + 1;
  localparam int MW = 2 * CB + 2;
  localparam int PW = 2 * CB + 3;

  function automatic logic signed [DW-1:0] sx(input logic signed [CB-1:0] v);
    return $signed({v[CB-1], v});
  endfunction

  function automatic logic signed [PW-1:0] ext(input logic signed [MW-1:0] v);
    return $signed({v[MW-1], v});
  endfunction

  logic signed [CB-1:0] s1_ax, s1_ay, s1_bx, s1_by, s2_ax, s2_ay, s2_bx, s2_by;
  logic signed [DW-1:0] s1_d1x, s1_d1y, s1_d2x, s1_d2y, s1_rx, s1_ry;
  logic signed [DW-1:0] s2_d1x, s2_d1y, s2_d2x, s2_d2y;
  logic                 s1_z1, s1_z2, s2_z1, s2_z2;
  logic signed [MW-1:0] p_11x, p_11y, p_22x, p_22y, p_r1x, p_r1y, p_r2x, p_r2y;
  logic signed [MW-1:0] p_12x, p_12y, p_c1, p_c2, p_n1, p_n2;

  always_ff @(posedge clk) begin
    if (en) begin
      s1_ax  <= a_sx;
      s1_ay  <= a_sy;
      s1_bx  <= b_sx;
      s1_by  <= b_sy;
      s1_d1x <= sx(a_ex) - sx(a_sx);
      s1_d1y <= sx(a_ey) - sx(a_sy);
      s1_d2x <= sx(b_ex) - sx(b_sx);
      s1_d2y <= sx(b_ey) - sx(b_sy);
      s1_rx  <= sx(a_sx) - sx(b_sx);
      s1_ry  <= sx(a_sy) - sx(b_sy);
      s1_z1  <= (a_ex == a_sx) && (a_ey == a_sy);
      s1_z2  <= (b_ex == b_sx) && (b_ey == b_sy);

      s2_ax  <= s1_ax;
      s2_ay  <= s1_ay;
      s2_bx  <= s1_bx;
      s2_by  <= s1_by;
      s2_d1x <= s1_d1x;
      s2_d1y <= s1_d1y;
      s2_d2x <= s1_d2x;
      s2_d2y <= s1_d2y;
      s2_z1  <= s1_z1;
      s2_z2  <= s1_z2;
      p_11x  <= s1_d1x * s1_d1x;
      p_11y  <= s1_d1y * s1_d1y;
      p_22x  <= s1_d2x * s1_d2x;
      p_22y  <= s1_d2y * s1_d2y;
      p_r1x  <= s1_rx * s1_d1x;
      p_r1y  <= s1_ry * s1_d1y;
      p_r2x  <= s1_rx * s1_d2x;
      p_r2y  <= s1_ry * s1_d2y;
      p_12x  <= s1_d1x * s1_d2x;
      p_12y  <= s1_d1y * s1_d2y;
      p_c1   <= s1_d1x * s1_d2y;
      p_c2   <= s1_d1y * s1_d2x;
      p_n1   <= s1_d2x * s1_ry;
      p_n2   <= s1_d2y * s1_rx;

      ax  <= s2_ax;
      ay  <= s2_ay;
      bx  <= s2_bx;
      by  <= s2_by;
      d1x <= s2_d1x;
      d1y <= s2_d1y;
      d2x <= s2_d2x;
      d2y <= s2_d2y;
      z1  <= s2_z1;
      z2  <= s2_z2;
      dd1 <= ext(p_11x) + ext(p_11y);
      dd2 <= ext(p_22x) + ext(p_22y);
      rd1 <= ext(p_r1x) + ext(p_r1y);
      rd2 <= ext(p_r2x) + ext(p_r2y);
      d12 <= ext(p_12x) + ext(p_12y);
      cr  <= ext(p_c1) - ext(p_c2);
      cn  <= ext(p_n1) - ext(p_n2);
    end
  end

endmodule
`default_nettype wire

// ===== src/spcp_back.sv =====
// Back end: parameter select, closest point interpolation and squared gap, six stages.
// Depends on spcp_pkg for the select code.
`default_nettype none
module spcp_back #(
  parameter int CB = 24,
  parameter int PB = 16
) (
  input  wire logic                 clk,
  input  wire logic                 en,
  input  wire logic signed [CB-1:0] ax,
  input  wire logic signed [CB-1:0] ay,
  input  wire logic signed [CB-1:0] bx,
  input  wire logic signed [CB-1:0] by,
  input  wire logic signed [CB:0]   d1x,
  input  wire logic signed [CB:0]   d1y,
  input  wire logic signed [CB:0]   d2x,
  input  wire logic signed [CB:0]   d2y,
  input  wire logic        [PB:0]   q,
  input  wire spcp_pkg::sel_t       sel,
  input  wire logic        [PB:0]   f1k,
  input  wire logic        [PB:0]   f2k,
  output logic signed [CB-1:0]      near_a_x,
  output logic signed [CB-1:0]      near_a_y,
  output logic signed [CB-1:0]      near_b_x,
  output logic signed [CB-1:0]      near_b_y,
  output logic        [PB:0]        param_a,
  output logic        [PB:0]        param_b,
  output logic        [2*CB+1:0]    gap_squared
);

  localparam int RW = CB + PB + 1;

  logic signed [CB-1:0] pin [4];
  logic signed [CB:0]   din [4];
  logic        [PB:0]   f1, f2;

  logic        [PB:0]   b1_f1, b1_f2, b2_f1, b2_f2, b3_f1, b3_f2, b4_f1, b4_f2, b5_f1, b5_f2;
  logic signed [CB-1:0] b1_p [4];
  logic signed [CB-1:0] b2_p [4];
  logic signed [CB-1:0] near [4];
  logic signed [CB-1:0] b4_near [4];
  logic signed [CB-1:0] b5_near [4];
  logic        [CB-1:0] b1_mag [4];
  logic                 b1_neg [4];
  logic                 b2_neg [4];
  logic        [RW-1:0] b2_prod [4];
  logic signed [CB:0]   b4_gx, b4_gy;
  logic        [2*CB+1:0] b5_sx, b5_sy;

  assign pin[0] = ax;
  assign pin[1] = ay;
  assign pin[2] = bx;
  assign pin[3] = by;
  assign din[0] = d1x;
  assign din[1] = d1y;
  assign din[2] = d2x;
  assign din[3] = d2y;
  assign f1 = (sel == spcp_pkg::SEL_F1) ? q : f1k;
  assign f2 = (sel == spcp_pkg::SEL_F2) ? q : f2k;

  for (genvar i = 0; i < 4; i++) begin : g_lane
    logic signed [CB:0]   nd;
    logic        [RW-1:0] rnd;
    logic signed [CB+1:0] pos;
    always_comb begin
      nd  = -din[i];
      rnd = (b2_prod[i] + {{(RW-PB){1'b0}}, 1'b1, {(PB-1){1'b0}}}) >> PB;
      if (b2_neg[i]) begin
        pos = $signed({b2_p[i][CB-1], b2_p[i][CB-1], b2_p[i]}) - $signed({1'b0, rnd[CB:0]});
      end else begin
        pos = $signed({b2_p[i][CB-1], b2_p[i][CB-1], b2_p[i]}) + $signed({1'b0, rnd[CB:0]});
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        b1_p[i]    <= pin[i];
        b1_neg[i]  <= din[i][CB];
        b1_mag[i]  <= din[i][CB] ? nd[CB-1:0] : din[i][CB-1:0];
        b2_p[i]    <= b1_p[i];
        b2_neg[i]  <= b1_neg[i];
        b2_prod[i] <= b1_mag[i] * ((i < 2) ? b1_f1 : b1_f2);
        near[i]    <= pos[CB-1:0];
        b4_near[i] <= near[i];
        b5_near[i] <= b4_near[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b1_f1 <= f1;
      b1_f2 <= f2;
      b2_f1 <= b1_f1;
      b2_f2 <= b1_f2;
      b3_f1 <= b2_f1;
      b3_f2 <= b2_f2;
      b4_f1 <= b3_f1;
      b4_f2 <= b3_f2;
      b4_gx <= $signed({near[0][CB-1], near[0]}) - $signed({near[2][CB-1], near[2]});
      b4_gy <= $signed({near[1][CB-1], near[1]}) - $signed({near[3][CB-1], near[3]});
      b5_f1 <= b4_f1;
      b5_f2 <= b4_f2;
      b5_sx <= b4_gx * b4_gx;
      b5_sy <= b4_gy * b4_gy;
      near_a_x    <= b5_near[0];
      near_a_y    <= b5_near[1];
      near_b_x    <= b5_near[2];
      near_b_y    <= b5_near[3];
      param_a     <= b5_f1;
      param_b     <= b5_f2;
      gap_squared <= b5_sx + b5_sy;
    end
  end

endmodule
`default_nettype wire

// ===== src/segment_pair_closest_points_top.sv =====
// Top level of the closest points between two 2D segments pipeline.
// Depends on spcp_pkg, spcp_front, spcp_div, spcp_delay and spcp_back.
//
// Channel  | Handshake            | Payload
// input    | in_valid / in_ready  | seg_a_*, seg_b_* endpoints, signed Q12.12
// output   | out_valid / out_ready| near_*, param_a, param_b, gap_squared
//
// One transaction is accepted every cycle while the pipeline advances; the pipeline
// holds two bit-per-stage dividers of PARAM_FRAC_BITS + 2 stages each.
// The whole pipeline advances together; it holds only when the output is full and not taken.
// Reset clears the valid bits only; the datapath registers carry no reset.
`default_nettype none
module segment_pair_closest_points_top #(
  parameter int COORD_BITS      = 24,
  parameter int PARAM_FRAC_BITS = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic signed [COORD_BITS-1:0]  seg_a_start_x,
  input  wire logic signed [COORD_BITS-1:0]  seg_a_start_y,
  input  wire logic signed [COORD_BITS-1:0]  seg_a_end_x,
  input  wire logic signed [COORD_BITS-1:0]  seg_a_end_y,
  input  wire logic signed [COORD_BITS-1:0]  seg_b_start_x,
  input  wire logic signed [COORD_BITS-1:0]  seg_b_start_y,
  input  wire logic signed [COORD_BITS-1:0]  seg_b_end_x,
  input  wire logic signed [COORD_BITS-1:0]  seg_b_end_y,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic signed [COORD_BITS-1:0]       near_a_x,
  output logic signed [COORD_BITS-1:0]       near_a_y,
  output logic signed [COORD_BITS-1:0]       near_b_x,
  output logic signed [COORD_BITS-1:0]       near_b_y,
  output logic        [PARAM_FRAC_BITS:0]    param_a,
  output logic        [PARAM_FRAC_BITS:0]    param_b,
  output logic        [2*COORD_BITS+1:0]     gap_squared
);

  localparam int CB   = COORD_BITS;
  localparam int PB   = PARAM_FRAC_BITS;
  localparam int PW   = 2 * CB + 3;
  localparam int NW   = PW + PB + 2;
  localparam int DLAT = PB + 2;
  localparam int LAT  = 3 + DLAT + 3 + DLAT + 6;
  localparam int SW   = $bits(spcp_pkg::sel_t);

  function automatic logic signed [NW-1:0] ext_p(input logic signed [PW-1:0] v);
    return $signed({{(NW-PW){v[PW-1]}}, v});
  endfunction

  function automatic logic signed [NW-1:0] ext_p1(input logic signed [PW:0] v);
    return $signed({{(NW-PW-1){v[PW]}}, v});
  endfunction

  logic           en;
  logic [LAT-1:0] vld;

  assign en        = !vld[LAT-1] || out_ready;
  assign in_ready  = en;
  assign out_valid = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], in_valid};
    end
  end

  logic signed [CB-1:0] f_ax, f_ay, f_bx, f_by;
  logic signed [CB:0]   f_d1x, f_d1y, f_d2x, f_d2y;
  logic                 f_z1, f_z2;
  logic signed [PW-1:0] f_dd1, f_dd2, f_rd1, f_rd2, f_d12, f_cr, f_cn;

  spcp_front #(.CB(CB)) u_front (
    .clk(clk), .en(en),
    .a_sx(seg_a_start_x), .a_sy(seg_a_start_y), .a_ex(seg_a_end_x), .a_ey(seg_a_end_y),
    .b_sx(seg_b_start_x), .b_sy(seg_b_start_y), .b_ex(seg_b_end_x), .b_ey(seg_b_end_y),
    .ax(f_ax), .ay(f_ay), .bx(f_bx), .by(f_by),
    .d1x(f_d1x), .d1y(f_d1y), .d2x(f_d2x), .d2y(f_d2y),
    .z1(f_z1), .z2(f_z2),
    .dd1(f_dd1), .dd2(f_dd2), .rd1(f_rd1), .rd2(f_rd2), .d12(f_d12), .cr(f_cr), .cn(f_cn)
  );

  logic [PB:0] q1;

  spcp_div #(.W(PW), .QB(PB)) u_div1 (
    .clk(clk), .en(en), .num(f_cn), .den(f_cr), .q(q1)
  );

  logic [PW-1:0] j_dd1, j_dd2, j_rd1, j_rd2, j_d12;
  logic [1:0]    j_z;

  spcp_delay #(.W(PW), .DEPTH(DLAT)) u_dl_dd1 (.clk(clk), .en(en), .d(f_dd1), .q(j_dd1));
  spcp_delay #(.W(PW), .DEPTH(DLAT)) u_dl_dd2 (.clk(clk), .en(en), .d(f_dd2), .q(j_dd2));
  spcp_delay #(.W(PW), .DEPTH(DLAT)) u_dl_rd1 (.clk(clk), .en(en), .d(f_rd1), .q(j_rd1));
  spcp_delay #(.W(PW), .DEPTH(DLAT)) u_dl_rd2 (.clk(clk), .en(en), .d(f_rd2), .q(j_rd2));
  spcp_delay #(.W(PW), .DEPTH(DLAT)) u_dl_d12 (.clk(clk), .en(en), .d(f_d12), .q(j_d12));
  spcp_delay #(.W(2), .DEPTH(DLAT)) u_dl_z (.clk(clk), .en(en), .d({f_z1, f_z2}), .q(j_z));

  logic signed [NW-1:0] m1_prod, m2_n;
  logic signed [PW-1:0] m1_rd1, m1_rd2, m1_d12, m1_dd1, m1_dd2;
  logic signed [PW-1:0] m2_rd2, m2_dd1, m2_dd2;
  logic signed [PW:0]   m2_nrd1, m2_drd;
  logic                 m1_z1, m1_z2, m2_z1, m2_z2;
  logic [PB:0]          m1_f1, m2_f1;

  always_ff @(posedge clk) begin
    if (en) begin
      m1_prod <= $signed(j_d12) * $signed({1'b0, q1});
      m1_rd1  <= j_rd1;
      m1_rd2  <= j_rd2;
      m1_d12  <= j_d12;
      m1_dd1  <= j_dd1;
      m1_dd2  <= j_dd2;
      m1_z1   <= j_z[1];
      m1_z2   <= j_z[0];
      m1_f1   <= q1;

      m2_n    <= m1_prod + (ext_p(m1_rd2) <<< PB);
      m2_nrd1 <= -$signed({m1_rd1[PW-1], m1_rd1});
      m2_drd  <= $signed({m1_d12[PW-1], m1_d12}) - $signed({m1_rd1[PW-1], m1_rd1});
      m2_rd2  <= m1_rd2;
      m2_dd1  <= m1_dd1;
      m2_dd2  <= m1_dd2;
      m2_z1   <= m1_z1;
      m2_z2   <= m1_z2;
      m2_f1   <= m1_f1;
    end
  end

  logic signed [NW-1:0] den2;
  logic signed [NW-1:0] num_next, den_next;
  spcp_pkg::sel_t       sel_next;
  logic [PB:0]          f1k_next, f2k_next;

  assign den2 = ext_p(m2_dd2) <<< PB;

  always_comb begin
    num_next = '0;
    den_next = '0;
    sel_next = spcp_pkg::SEL_NONE;
    f1k_next = '0;
    f2k_next = '0;
    priority if (m2_z1 || m2_z2) begin
      if (!m2_z1) begin
        num_next = ext_p1(m2_nrd1);
        den_next = ext_p(m2_dd1);
        sel_next = spcp_pkg::SEL_F1;
      end else if (!m2_z2) begin
        num_next = ext_p(m2_rd2);
        den_next = ext_p(m2_dd2);
        sel_next = spcp_pkg::SEL_F2;
      end
    end else if (m2_n[NW-1]) begin
      num_next = ext_p1(m2_nrd1);
      den_next = ext_p(m2_dd1);
      sel_next = spcp_pkg::SEL_F1;
    end else if (m2_n > den2) begin
      num_next = ext_p1(m2_drd);
      den_next = ext_p(m2_dd1);
      sel_next = spcp_pkg::SEL_F1;
      f2k_next = {1'b1, {PB{1'b0}}};
    end else begin
      num_next = m2_n;
      den_next = den2;
      sel_next = spcp_pkg::SEL_F2;
      f1k_next = m2_f1;
    end
  end

  logic signed [NW-1:0] m3_num, m3_den;
  spcp_pkg::sel_t       m3_sel;
  logic [PB:0]          m3_f1k, m3_f2k;

  always_ff @(posedge clk) begin
    if (en) begin
      m3_num <= num_next;
      m3_den <= den_next;
      m3_sel <= sel_next;
      m3_f1k <= f1k_next;
      m3_f2k <= f2k_next;
    end
  end

  logic [PB:0] q2;

  spcp_div #(.W(NW), .QB(PB)) u_div2 (
    .clk(clk), .en(en), .num(m3_num), .den(m3_den), .q(q2)
  );

  logic [SW-1:0] k_sel;
  logic [PB:0]   k_f1k, k_f2k;

  spcp_delay #(.W(SW), .DEPTH(DLAT)) u_dl_sel (.clk(clk), .en(en), .d(m3_sel), .q(k_sel));
  spcp_delay #(.W(PB+1), .DEPTH(DLAT)) u_dl_f1k (.clk(clk), .en(en), .d(m3_f1k), .q(k_f1k));
  spcp_delay #(.W(PB+1), .DEPTH(DLAT)) u_dl_f2k (.clk(clk), .en(en), .d(m3_f2k), .q(k_f2k));

  localparam int CDEP = 2 * DLAT + 3;

  logic [CB-1:0] k_ax, k_ay, k_bx, k_by;
  logic [CB:0]   k_d1x, k_d1y, k_d2x, k_d2y;

  spcp_delay #(.W(CB), .DEPTH(CDEP)) u_dl_ax (.clk(clk), .en(en), .d(f_ax), .q(k_ax));
  spcp_delay #(.W(CB), .DEPTH(CDEP)) u_dl_ay (.clk(clk), .en(en), .d(f_ay), .q(k_ay));
  spcp_delay #(.W(CB), .DEPTH(CDEP)) u_dl_bx (.clk(clk), .en(en), .d(f_bx), .q(k_bx));
  spcp_delay #(.W(CB), .DEPTH(CDEP)) u_dl_by (.clk(clk), .en(en), .d(f_by), .q(k_by));
  spcp_delay #(.W(CB+1), .DEPTH(CDEP)) u_dl_d1x (.clk(clk), .en(en), .d(f_d1x), .q(k_d1x));
  spcp_delay #(.W(CB+1), .DEPTH(CDEP)) u_dl_d1y (.clk(clk), .en(en), .d(f_d1y), .q(k_d1y));
  spcp_delay #(.W(CB+1), .DEPTH(CDEP)) u_dl_d2x (.clk(clk), .en(en), .d(f_d2x), .q(k_d2x));
  spcp_delay #(.W(CB+1), .DEPTH(CDEP)) u_dl_d2y (.clk(clk), .en(en), .d(f_d2y), .q(k_d2y));

  spcp_back #(.CB(CB), .PB(PB)) u_back (
    .clk(clk), .en(en),
    .ax($signed(k_ax)), .ay($signed(k_ay)), .bx($signed(k_bx)), .by($signed(k_by)),
    .d1x($signed(k_d1x)), .d1y($signed(k_d1y)), .d2x($signed(k_d2x)), .d2y($signed(k_d2y)),
    .q(q2), .sel(spcp_pkg::sel_t'(k_sel)), .f1k(k_f1k), .f2k(k_f2k),
    .near_a_x(near_a_x), .near_a_y(near_a_y), .near_b_x(near_b_x), .near_b_y(near_b_y),
    .param_a(param_a), .param_b(param_b), .gap_squared(gap_squared)
  );

endmodule
`default_nettype wire
